[hw/rtl/scanline_sine_wave_scroll_assert.svh]
// Assertion macros shared by the scanline wave scroll RTL.
`ifndef SCANLINE_SINE_WAVE_SCROLL_ASSERT_SVH
`define SCANLINE_SINE_WAVE_SCROLL_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SSWS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SSWS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/ssws_pkg.sv]
// Types, constants and the sine table builder of the scanline wave scroll block.
package ssws_pkg;

    // Field and register widths.
    localparam int LINE_W      = 8;
    localparam int WORD_W      = 32;
    localparam int HALF_W      = 16;
    localparam int ANGLE_W     = 16;
    localparam int AMP_W       = 20;
    localparam int SPEED_W     = 14;
    localparam int POS_W       = 15;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;

    // Shared multiplier: operand width and product width.
    localparam int MUL_W       = 17;
    localparam int PROD_W      = 2 * MUL_W;

    // Sine: quarter-wave table of 1.12 values and the wave scaling shift.
    localparam int QSIN_W      = 13;
    localparam int SIN_W       = QSIN_W + 1;
    localparam int QTAB_N      = 1025;
    localparam int QIDX_W      = 11;
    localparam int WAVE_SH     = 24;
    localparam int VERT_SHIFT  = 180;

    localparam logic [LINE_W-1:0] BAND_END_RST = 8'd191;
    localparam logic [63:0]       HALF_PI_Q30  = 64'h6487ED51;

    // Input item kind.
    typedef enum logic {
        OP_QUERY = 1'b0,
        OP_FRAME = 1'b1
    } t_op;

    // Register indexes, byte address 4*index.
    typedef enum logic [2:0] {
        REG_BAND_START = 3'd0,
        REG_BAND_END   = 3'd1,
        REG_ANGLE_STEP = 3'd2,
        REG_AMPLITUDE  = 3'd3,
        REG_SPEED      = 3'd4,
        REG_BASE_WORD  = 3'd5,
        REG_AXIS       = 3'd6
    } t_reg_idx;

    // Configuration register file contents.
    typedef struct packed {
        logic [LINE_W-1:0]         band_start;
        logic [LINE_W-1:0]         band_end;
        logic [ANGLE_W-1:0]        angle_step;
        logic signed [AMP_W-1:0]   amplitude;
        logic signed [SPEED_W-1:0] speed;
        logic [WORD_W-1:0]         base_word;
        logic                      axis;
    } t_cfg;

    // Datapath commands issued by the controller.
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_DIV_MUL,
        DP_DIV_BACK,
        DP_DIV_FIX,
        DP_MOD_MUL,
        DP_MOD_BACK,
        DP_MOD_FIX,
        DP_ANGLE,
        DP_WAVE_MUL,
        DP_POS_SUM,
        DP_POS_MUL,
        DP_POS_BACK,
        DP_POS_FIX,
        DP_EMIT
    } t_dp_cmd;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_MUL,
        S_DIV_BACK,
        S_DIV_FIX,
        S_MOD_MUL,
        S_MOD_BACK,
        S_MOD_FIX,
        S_ANGLE,
        S_WAVE_MUL,
        S_POS_SUM,
        S_POS_MUL,
        S_POS_BACK,
        S_POS_FIX,
        S_EMIT
    } t_state;

    // Classification of the item presented at the input.
    typedef struct packed {
        logic frame;
        logic in_band;
    } t_dp_status;

    typedef logic [QSIN_W-1:0] t_qsin_tab [QTAB_N];

    // round(4096 * sin(k * (pi/2) / 1024)) by a fixed-point Taylor series in Q30.
    function automatic logic [QSIN_W-1:0] quarter_sine(input logic [QIDX_W-1:0] k);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        rnd;
        if (k == '0) begin
            return '0;
        end
        x    = (64'(k) * HALF_PI_Q30 + 64'd512) >> 10;
        x2   = (x * x) >> 30;
        sum  = $signed(x);
        term = x;
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd210;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd272;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd342;
        sum  = sum - $signed(term);
        if (sum < 0) begin
            sum = '0;
        end
        rnd = (($unsigned(sum) << 12) + (64'd1 << 29)) >> 30;
        return rnd[QSIN_W-1:0];
    endfunction

    // Whole quarter-wave table, built at elaboration in rows of 32 entries.
    function automatic t_qsin_tab qsin_table();
        t_qsin_tab tab;
        int        k;
        for (int row = 0; row < (QTAB_N + 31) / 32; row++) begin
            for (int col = 0; col < 32; col++) begin
                k = row * 32 + col;
                if (k < QTAB_N) begin
                    tab[k] = quarter_sine(QIDX_W'(k));
                end
            end
        end
        return tab;
    endfunction

endpackage

[hw/rtl/ssws_regs.sv]
// Configuration register file with its APB-style port.
module ssws_regs
    import ssws_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg,
    output logic              o_pos_clr
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;
    logic       idx_hit;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];

    // A write to a listed register also restarts the scroll position.
    always_comb begin
        unique case (reg_idx) inside
            REG_BAND_START, REG_BAND_END, REG_ANGLE_STEP, REG_AMPLITUDE,
            REG_SPEED, REG_BASE_WORD, REG_AXIS: idx_hit = 1'b1;
            default: idx_hit = 1'b0;
        endcase
    end

    assign o_pos_clr = wr_en & idx_hit;
    assign o_cfg     = r_cfg;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.band_start <= '0;
            r_cfg.band_end   <= BAND_END_RST;
            r_cfg.angle_step <= '0;
            r_cfg.amplitude  <= '0;
            r_cfg.speed      <= '0;
            r_cfg.base_word  <= '0;
            r_cfg.axis       <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_BAND_START: r_cfg.band_start <= pwdata[LINE_W-1:0];
                REG_BAND_END:   r_cfg.band_end   <= pwdata[LINE_W-1:0];
                REG_ANGLE_STEP: r_cfg.angle_step <= pwdata[ANGLE_W-1:0];
                REG_AMPLITUDE:  r_cfg.amplitude  <= $signed(pwdata[AMP_W-1:0]);
                REG_SPEED:      r_cfg.speed      <= $signed(pwdata[SPEED_W-1:0]);
                REG_BASE_WORD:  r_cfg.base_word  <= pwdata[WORD_W-1:0];
                REG_AXIS:       r_cfg.axis       <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read data mux.
    always_comb begin
        unique case (reg_idx)
            REG_BAND_START: prdata = DATA_W'(r_cfg.band_start);
            REG_BAND_END:   prdata = DATA_W'(r_cfg.band_end);
            REG_ANGLE_STEP: prdata = DATA_W'(r_cfg.angle_step);
            REG_AMPLITUDE:  prdata = DATA_W'($unsigned(r_cfg.amplitude));
            REG_SPEED:      prdata = DATA_W'($unsigned(r_cfg.speed));
            REG_BASE_WORD:  prdata = r_cfg.base_word;
            REG_AXIS:       prdata = DATA_W'(r_cfg.axis);
            default:        prdata = '0;
        endcase
    end

endmodule

[hw/rtl/ssws_ctrl.sv]
// Controller state machine that sequences the wave scroll datapath.
`include "scanline_sine_wave_scroll_assert.svh"

module ssws_ctrl
    import ssws_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_m_tvalid,
    input  logic       i_m_tready
);

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    logic    n_out_valid;
    t_dp_cmd cmd;
    logic    s_ready;

    // State and output-valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath command.
    always_comb begin
        n_state = r_state;
        cmd     = DP_NOP;
        s_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                s_ready = 1'b1;
                if (i_s_tvalid) begin
                    cmd = DP_LOAD;
                    if (i_status.frame) begin
                        n_state = S_POS_SUM;
                    end else if (i_status.in_band) begin
                        n_state = S_DIV_MUL;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_DIV_MUL: begin
                cmd     = DP_DIV_MUL;
                n_state = S_DIV_BACK;
            end
            S_DIV_BACK: begin
                cmd     = DP_DIV_BACK;
                n_state = S_DIV_FIX;
            end
            S_DIV_FIX: begin
                cmd     = DP_DIV_FIX;
                n_state = S_MOD_MUL;
            end
            S_MOD_MUL: begin
                cmd     = DP_MOD_MUL;
                n_state = S_MOD_BACK;
            end
            S_MOD_BACK: begin
                cmd     = DP_MOD_BACK;
                n_state = S_MOD_FIX;
            end
            S_MOD_FIX: begin
                cmd     = DP_MOD_FIX;
                n_state = S_ANGLE;
            end
            S_ANGLE: begin
                cmd     = DP_ANGLE;
                n_state = S_WAVE_MUL;
            end
            S_WAVE_MUL: begin
                cmd     = DP_WAVE_MUL;
                n_state = S_EMIT;
            end
            S_POS_SUM: begin
                cmd     = DP_POS_SUM;
                n_state = S_POS_MUL;
            end
            S_POS_MUL: begin
                cmd     = DP_POS_MUL;
                n_state = S_POS_BACK;
            end
            S_POS_BACK: begin
                cmd     = DP_POS_BACK;
                n_state = S_POS_FIX;
            end
            S_POS_FIX: begin
                cmd     = DP_POS_FIX;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                // The result register takes the item once it is free.
                if (!r_out_valid || i_m_tready) begin
                    cmd     = DP_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: ;
        endcase
    end

    // Output valid: set when a result is emitted, cleared when the transaction completes.
    always_comb begin
        if (cmd == DP_EMIT) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_cmd      = cmd;
    assign o_s_tready = s_ready;
    assign o_m_tvalid = r_out_valid;

    `SSWS_ASSERT_NXT(a_one_in_flight, i_clk, i_rst_n, i_s_tvalid && s_ready, !s_ready, "second item taken while busy")
    `SSWS_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, r_out_valid && !i_m_tready, cmd != DP_EMIT, "stalled result overwritten")
    `SSWS_ASSERT_NXT(a_emit_valid, i_clk, i_rst_n, cmd == DP_EMIT, r_out_valid, "loaded result not shown as valid")

endmodule

[hw/rtl/ssws_dp.sv]
// Datapath: scroll position, shared multiplier, sine table and result register.
`include "scanline_sine_wave_scroll_assert.svh"

module ssws_dp
    import ssws_pkg::*;
#(
    parameter int LINES   = 192,
    parameter int SCALE   = 100,
    parameter int MAX_POS = 19200
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_status,
    input  t_cfg              i_cfg,
    input  logic              i_pos_clr,
    input  logic              i_op,
    input  logic [LINE_W-1:0] i_line,
    output logic [WORD_W-1:0] o_word,
    output logic              o_in_band
);

    // Reciprocal constants for division by a constant: the estimate is exact or one low.
    localparam int DIV_SH  = POS_W;
    localparam int MOD_SH  = 16;
    localparam int POS_SH  = MUL_W;
    localparam int R_SCALE = (1 << DIV_SH) / SCALE;
    localparam int R_LINES = (1 << MOD_SH) / LINES;
    localparam int R_POS   = (1 << POS_SH) / MAX_POS;
    localparam int SPD_MAG = 1 << (SPEED_W - 1);
    localparam int POS_OFS = MAX_POS * ((SPD_MAG + MAX_POS - 1) / MAX_POS);
    localparam int VSHIFT  = VERT_SHIFT % LINES;

    localparam t_qsin_tab QSIN_ROM = qsin_table();

    // State and working registers.
    logic [POS_W-1:0]  r_pos;
    t_op               r_op;
    logic              r_in_band;
    logic [LINE_W-1:0] r_line_diff;
    logic [PROD_W-1:0] r_prod;
    logic [MUL_W-1:0]  r_quo;
    logic [MUL_W-1:0]  r_qm;
    logic [MOD_SH-1:0] r_sum;
    logic [MUL_W-1:0]  r_v;
    logic [LINE_W-1:0] r_idx;
    logic [QSIN_W-1:0] r_qsin;
    logic              r_neg;
    logic [WORD_W-1:0] r_out_word;
    logic              r_out_band;

    logic                     band_now;
    logic [MUL_W-1:0]         mul_a;
    logic [MUL_W-1:0]         mul_b;
    logic [PROD_W-1:0]        mul_p;
    logic [MUL_W-1:0]         quo_est;
    logic [MUL_W-1:0]         back_d;
    logic [PROD_W-1:0]        qm_p;
    logic [MUL_W-1:0]         div_rem;
    logic [MUL_W-1:0]         div_q;
    logic [MOD_SH-1:0]        sum_new;
    logic [MUL_W-1:0]         mod_rem;
    logic [8:0]               idx0;
    logic [8:0]               idx_v;
    logic [8:0]               idx1;
    logic [2*ANGLE_W-1:0]     angle_p;
    logic [ANGLE_W-1:0]       angle;
    logic [1:0]               quad;
    logic [9:0]               frac;
    logic [QIDX_W-1:0]        rom_addr;
    logic signed [SIN_W-1:0]  sin_s;
    logic signed [PROD_W-1:0] wprod;
    logic signed [17:0]       v_s;
    logic [MUL_W-1:0]         pos_rem;
    logic [MUL_W-1:0]         pos_new;
    logic signed [9:0]        wave;
    logic [HALF_W-1:0]        wave16;
    logic [WORD_W-1:0]        word_new;
    logic                     band_new;

    // Classification of the presented item.
    assign band_now          = (i_line >= i_cfg.band_start) && (i_line <= i_cfg.band_end);
    assign o_status.frame    = (t_op'(i_op) == OP_FRAME);
    assign o_status.in_band  = band_now;

    // Shared multiplier against a reciprocal constant.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd)
            DP_DIV_MUL: begin
                mul_a = MUL_W'(r_pos);
                mul_b = MUL_W'(R_SCALE);
            end
            DP_MOD_MUL: begin
                mul_a = MUL_W'(r_sum);
                mul_b = MUL_W'(R_LINES);
            end
            DP_POS_MUL: begin
                mul_a = r_v;
                mul_b = MUL_W'(R_POS);
            end
            default: ;
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Quotient estimate and its multiple of the divisor.
    always_comb begin
        quo_est = '0;
        back_d  = '0;
        case (i_cmd)
            DP_DIV_BACK: begin
                quo_est = MUL_W'(r_prod >> DIV_SH);
                back_d  = MUL_W'(SCALE);
            end
            DP_MOD_BACK: begin
                quo_est = MUL_W'(r_prod >> MOD_SH);
                back_d  = MUL_W'(LINES);
            end
            DP_POS_BACK: begin
                quo_est = MUL_W'(r_prod >> POS_SH);
                back_d  = MUL_W'(MAX_POS);
            end
            default: ;
        endcase
    end

    assign qm_p = PROD_W'(quo_est) * PROD_W'(back_d);

    // Position over scale, corrected, plus the line's distance into the band.
    assign div_rem = MUL_W'(r_pos) - r_qm;
    assign div_q   = (div_rem >= MUL_W'(SCALE)) ? r_quo + MUL_W'(1) : r_quo;
    assign sum_new = MOD_SH'(div_q) + MOD_SH'(r_line_diff);

    // Table index modulo the line count, shifted for the vertical axis.
    assign mod_rem = MUL_W'(r_sum) - r_qm;
    assign idx0    = (mod_rem[8:0] >= 9'(LINES)) ? mod_rem[8:0] - 9'(LINES) : mod_rem[8:0];
    assign idx_v   = idx0 + 9'(VSHIFT);
    assign idx1    = (idx_v >= 9'(LINES)) ? idx_v - 9'(LINES) : idx_v;

    // Angle and quarter-wave table address.
    assign angle_p  = (2*ANGLE_W)'(r_idx) * (2*ANGLE_W)'(i_cfg.angle_step);
    assign angle    = angle_p[ANGLE_W-1:0];
    assign quad     = angle[ANGLE_W-1 -: 2];
    assign frac     = angle[ANGLE_W-3:4];
    assign rom_addr = quad[0] ? QIDX_W'(1024) - QIDX_W'(frac) : QIDX_W'(frac);

    // Signed sine times amplitude.
    assign sin_s = r_neg ? -$signed({1'b0, r_qsin}) : $signed({1'b0, r_qsin});
    assign wprod = PROD_W'(sin_s) * PROD_W'(i_cfg.amplitude);

    // Frame advance: position plus speed, offset by a multiple of the range to stay positive.
    assign v_s     = $signed({3'b000, r_pos}) + 18'(POS_OFS) + 18'(i_cfg.speed);
    assign pos_rem = r_v - r_qm;
    assign pos_new = (pos_rem >= MUL_W'(MAX_POS)) ? pos_rem - MUL_W'(MAX_POS) : pos_rem;

    // Result composition.
    assign wave   = $signed(r_prod[PROD_W-1:WAVE_SH]);
    assign wave16 = HALF_W'(wave);

    always_comb begin
        word_new = '0;
        band_new = 1'b0;
        if (r_op == OP_QUERY) begin
            if (!r_in_band) begin
                word_new = i_cfg.base_word;
            end else if (i_cfg.axis) begin
                word_new = {i_cfg.base_word[WORD_W-1:HALF_W] + wave16,
                            i_cfg.base_word[HALF_W-1:0]};
                band_new = 1'b1;
            end else begin
                word_new = {i_cfg.base_word[WORD_W-1:HALF_W],
                            i_cfg.base_word[HALF_W-1:0] + wave16};
                band_new = 1'b1;
            end
        end
    end

    // Scroll position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_pos_clr) begin
            r_pos <= '0;
        end else if (i_cmd == DP_POS_FIX) begin
            r_pos <= pos_new[POS_W-1:0];
        end
    end

    // Working registers, loaded by command.
    always_ff @(posedge i_clk) begin
        case (i_cmd) inside
            DP_LOAD: begin
                r_op        <= t_op'(i_op);
                r_in_band   <= band_now;
                r_line_diff <= i_line - i_cfg.band_start;
            end
            DP_DIV_MUL, DP_MOD_MUL, DP_POS_MUL: r_prod <= mul_p;
            DP_DIV_BACK, DP_MOD_BACK, DP_POS_BACK: begin
                r_quo <= quo_est;
                r_qm  <= qm_p[MUL_W-1:0];
            end
            DP_DIV_FIX:  r_sum <= sum_new;
            DP_MOD_FIX:  r_idx <= i_cfg.axis ? idx1[LINE_W-1:0] : idx0[LINE_W-1:0];
            DP_ANGLE: begin
                r_qsin <= QSIN_ROM[rom_addr];
                r_neg  <= quad[1];
            end
            DP_WAVE_MUL: r_prod <= $unsigned(wprod);
            DP_POS_SUM:  r_v    <= v_s[MUL_W-1:0];
            DP_EMIT: begin
                r_out_word <= word_new;
                r_out_band <= band_new;
            end
            default: ;
        endcase
    end

    assign o_word    = r_out_word;
    assign o_in_band = r_out_band;

    `SSWS_ASSERT_IMP(a_pos_range, i_clk, i_rst_n, 1'b1, r_pos < POS_W'(MAX_POS), "scroll position out of range")
    `SSWS_ASSERT_NXT(a_idx_range, i_clk, i_rst_n, i_cmd == DP_MOD_FIX, r_idx < LINE_W'(LINES), "table index out of range")
    `SSWS_ASSERT_NXT(a_frame_band, i_clk, i_rst_n, i_cmd == DP_EMIT && r_op == OP_FRAME, !r_out_band, "frame item flagged in band")

endmodule

[hw/rtl/scanline_sine_wave_scroll.sv]
// Top level of the per-scanline sine wave scroll generator. Every item taken on the
// input stream gives exactly one result: a scanline query returns the 32-bit offset
// word for that line (base word, with the sine wave added to its x or y half when the
// line lies in the band) and an in-band flag; a frame item advances the scroll position
// and returns zero. The block works on one item at a time through a shared multiplier,
// a 1025-entry quarter-wave sine ROM and a sequencer, while the previous result may
// still wait in the output register. A query inside the band passes through the
// reciprocal multiply steps for position over scale and for the line modulo, the
// ROM read and the wave multiply; a frame item passes through the position update,
// and a query outside the band goes straight to the result register. Any register
// write resets the scroll position to zero; configuration must be written while idle.
module scanline_sine_wave_scroll
    import ssws_pkg::*;
#(
    parameter int LINES   = 192,
    parameter int SCALE   = 100,
    parameter int MAX_POS = 19200
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    // Input stream
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [LINE_W-1:0] i_s_tdata,   // [7:0] line
    input  logic              i_s_tuser,   // [0] op
    // Result stream
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [WORD_W-1:0] o_m_tdata,   // [31:0] offset_word
    output logic              o_m_tuser    // [0] in_band
);

    t_cfg       cfg;
    logic       pos_clr;
    t_dp_cmd    cmd;
    t_dp_status status;

    // Register file.
    ssws_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_cfg     (cfg),
        .o_pos_clr (pos_clr)
    );

    // Sequencer.
    ssws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready)
    );

    // Datapath.
    ssws_dp #(
        .LINES   (LINES),
        .SCALE   (SCALE),
        .MAX_POS (MAX_POS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_status  (status),
        .i_cfg     (cfg),
        .i_pos_clr (pos_clr),
        .i_op      (i_s_tuser),
        .i_line    (i_s_tdata),
        .o_word    (o_m_tdata),
        .o_in_band (o_m_tuser)
    );

endmodule
